FILE: hdl/ccam_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the month length table for the calendar clock.
// No dependencies.
package ccam_pkg;

    localparam logic [6:0]  MIN_PER_HOUR = 7'd60;
    localparam logic [6:0]  HOUR_PER_DAY = 7'd24;
    localparam logic [10:0] MIN_PER_DAY  = 11'd1440;
    localparam logic [10:0] DIV60_MUL    = 11'd1093;
    localparam int          DIV60_SHIFT  = 16;
    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_APR    = 4'd4;
    localparam logic [3:0]  MONTH_JUN    = 4'd6;
    localparam logic [3:0]  MONTH_SEP    = 4'd9;
    localparam logic [3:0]  MONTH_NOV    = 4'd11;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [4:0]  DAY_FIRST    = 5'd1;
    localparam logic [4:0]  LEN_SHORT    = 5'd28;
    localparam logic [4:0]  LEN_MID      = 5'd30;
    localparam logic [4:0]  LEN_LONG     = 5'd31;
    localparam logic [2:0]  WD_MONDAY    = 3'd0;
    localparam logic [2:0]  WD_SUNDAY    = 3'd6;
    localparam logic        FUNC_LOAD    = 1'b0;
    localparam logic        FUNC_ADD     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DAY,
        CMD_SPLIT,
        CMD_RESULT
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } ctl_t;

    typedef struct packed {
        logic start_add;
        logic days_zero;
        logic out_free;
    } stat_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
            len = LEN_MID;
        end else if (m == MONTH_FEB) begin
            len = LEN_SHORT;
        end else begin
            len = LEN_LONG;
        end
        return len;
    endfunction

endpackage

FILE: hdl/ccam_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the calendar clock: sequences load, the day walk
// and the final hour/minute split. Depends on ccam_pkg.
module ccam_ctrl import ccam_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = stat.start_add ? ST_WALK : ST_FINISH;
                end
            end
            ST_WALK: begin
                if (stat.days_zero) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        ctl.cmd  = CMD_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ctl.cmd  = s_tvalid ? CMD_LOAD : CMD_NONE;
            end
            ST_WALK: begin
                ctl.cmd = stat.days_zero ? CMD_SPLIT : CMD_DAY;
            end
            ST_FINISH: begin
                ctl.cmd = stat.out_free ? CMD_RESULT : CMD_NONE;
            end
            default: begin
                ctl.cmd = CMD_NONE;
            end
        endcase
    end

    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK && stat.days_zero |=> state_reg == ST_FINISH)
        else $error("day walk did not end on zero days");

    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.cmd == CMD_RESULT |-> stat.out_free)
        else $error("result written over a waiting item");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("accepted item not processed");

endmodule

FILE: hdl/ccam_dp.sv
`timescale 1ns / 1ps
// Datapath of the calendar clock: clock registers, minute counter, day stepper,
// hour/minute split and result register. Depends on ccam_pkg.
module ccam_dp import ccam_pkg::*; #(
    parameter int YEAR_BITS = 16,
    parameter int ADD_BITS  = 21,
    parameter int S_BITS    = 64,
    parameter int M_BITS    = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [S_BITS-1:0] s_tdata,
    input  logic              s_tuser,
    output logic [M_BITS-1:0] m_tdata,
    output logic [4:0]        m_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ctl_t              ctl,
    output stat_t             stat
);

    localparam int YEAR_LO   = 9;
    localparam int HOUR_LO   = YEAR_LO + YEAR_BITS;
    localparam int MIN_LO    = HOUR_LO + 5;
    localparam int WD_LO     = MIN_LO + 6;
    localparam int CNT_LO    = WD_LO + 3;
    localparam int WORK_BITS = (ADD_BITS > 12) ? ADD_BITS : 12;
    localparam logic [YEAR_BITS-1:0] YEAR_MAX   = {YEAR_BITS{1'b1}};
    localparam logic [YEAR_BITS-1:0] YEAR_RESET = YEAR_BITS'(2000);
    localparam logic [WORK_BITS-1:0] DAY_MINS   = WORK_BITS'(MIN_PER_DAY);

    logic [4:0]           in_day, in_hour;
    logic [3:0]           in_month;
    logic [YEAR_BITS-1:0] in_year;
    logic [5:0]           in_minute;
    logic [2:0]           in_wd;
    logic [ADD_BITS-1:0]  in_count;

    logic [5:0]           minute_reg, minute_next;
    logic [4:0]           hour_reg, hour_next;
    logic [4:0]           day_reg, day_next;
    logic [3:0]           month_reg, month_next;
    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [2:0]           weekday_reg, weekday_next;
    logic [WORK_BITS-1:0] work_reg, work_next;
    logic [4:0]           flags_reg, flags_next;
    logic [M_BITS-1:0]    out_data_reg, out_data_next;
    logic [4:0]           out_user_reg, out_user_next;
    logic                 out_valid_reg, out_valid_next;

    logic [10:0]          hour_mins;
    logic [21:0]          split_prod;
    logic [4:0]           split_hour;
    logic [10:0]          split_sub;
    logic                 date_ok, time_ok;

    assign in_day    = s_tdata[4:0];
    assign in_month  = s_tdata[8:5];
    assign in_year   = s_tdata[YEAR_LO +: YEAR_BITS];
    assign in_hour   = s_tdata[HOUR_LO +: 5];
    assign in_minute = s_tdata[MIN_LO +: 6];
    assign in_wd     = s_tdata[WD_LO +: 3];
    assign in_count  = s_tdata[CNT_LO +: ADD_BITS];

    assign date_ok = (in_month >= MONTH_JAN) && (in_month <= MONTH_DEC) &&
                     (in_day >= DAY_FIRST) && (in_day <= month_len(in_month));
    assign time_ok = (in_hour < HOUR_PER_DAY[4:0]) && (in_minute < MIN_PER_HOUR[5:0]);

    // minutes left below one day: hour by reciprocal multiply, minute by subtract
    assign hour_mins  = {6'd0, hour_reg} * {4'd0, MIN_PER_HOUR};
    assign split_prod = {11'd0, work_reg[10:0]} * {11'd0, DIV60_MUL};
    assign split_hour = split_prod[DIV60_SHIFT +: 5];
    assign split_sub  = work_reg[10:0] - {6'd0, split_hour} * {4'd0, MIN_PER_HOUR};

    assign stat.start_add = (s_tuser == FUNC_ADD) && !in_count[ADD_BITS-1];
    assign stat.days_zero = (work_reg < DAY_MINS);
    assign stat.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minute_reg    <= '0;
            hour_reg      <= '0;
            day_reg       <= DAY_FIRST;
            month_reg     <= MONTH_JAN;
            year_reg      <= YEAR_RESET;
            weekday_reg   <= WD_MONDAY;
            out_valid_reg <= 1'b0;
        end else begin
            minute_reg    <= minute_next;
            hour_reg      <= hour_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            weekday_reg   <= weekday_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg     <= work_next;
        flags_reg    <= flags_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    always_comb begin
        minute_next    = minute_reg;
        hour_next      = hour_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        weekday_next   = weekday_reg;
        work_next      = work_reg;
        flags_next     = flags_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (ctl.cmd)
            CMD_LOAD: begin
                flags_next = '0;
                work_next  = WORK_BITS'(in_count[ADD_BITS-2:0]) + WORK_BITS'(minute_reg) +
                             WORK_BITS'(hour_mins);
                if (s_tuser == FUNC_LOAD) begin
                    if (date_ok) begin
                        day_next   = in_day;
                        month_next = in_month;
                        year_next  = in_year;
                    end else begin
                        flags_next[0] = 1'b1;
                    end
                    if (time_ok) begin
                        hour_next   = in_hour;
                        minute_next = in_minute;
                    end else begin
                        flags_next[1] = 1'b1;
                    end
                    if (in_wd <= WD_SUNDAY) begin
                        weekday_next = in_wd;
                    end else begin
                        weekday_next  = WD_MONDAY;
                        flags_next[2] = 1'b1;
                    end
                end else if (in_count[ADD_BITS-1]) begin
                    flags_next[3] = 1'b1;
                end
            end
            CMD_DAY: begin
                work_next    = work_reg - DAY_MINS;
                weekday_next = (weekday_reg >= WD_SUNDAY) ? WD_MONDAY : weekday_reg + 1'b1;
                if (day_reg >= month_len(month_reg)) begin
                    day_next = DAY_FIRST;
                    if (month_reg >= MONTH_DEC) begin
                        month_next = MONTH_JAN;
                        if (year_reg == YEAR_MAX) begin
                            flags_next[4] = 1'b1;
                        end else begin
                            year_next = year_reg + 1'b1;
                        end
                    end else begin
                        month_next = month_reg + 1'b1;
                    end
                end else begin
                    day_next = day_reg + 1'b1;
                end
            end
            CMD_SPLIT: begin
                hour_next   = split_hour;
                minute_next = split_sub[5:0];
            end
            CMD_RESULT: begin
                out_data_next  = M_BITS'({weekday_reg, minute_reg, hour_reg,
                                          year_reg, month_reg, day_reg});
                out_user_next  = flags_reg;
                out_valid_next = 1'b1;
            end
            default: begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tvalid = out_valid_reg;

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        day_reg >= DAY_FIRST && day_reg <= month_len(month_reg))
        else $error("day outside its month");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        month_reg >= MONTH_JAN && month_reg <= MONTH_DEC)
        else $error("month out of range");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hour_reg < HOUR_PER_DAY[4:0] && minute_reg < MIN_PER_HOUR[5:0] &&
        weekday_reg <= WD_SUNDAY)
        else $error("time or weekday out of range");

endmodule

FILE: hdl/calendar_clock_add_minutes.sv
`timescale 1ns / 1ps
// Calendar clock without leap years: load date/time/weekday or add minutes.
// A load item or a rejected add goes from accept straight to the finish state, which
// writes the result register once the output is free; an add item first walks one day
// per cycle (at most 729 at ADD_BITS = 21), then splits the rest into hour and minute.
// One item at a time: a new item is taken only once the last result is registered.
// Reset (aresetn low, synchronous) sets 00:00, 1 January 2000, Monday.
module calendar_clock_add_minutes import ccam_pkg::*; #(
    parameter int YEAR_BITS = 16,
    parameter int ADD_BITS  = 21
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // set_day, set_month, set_year, set_hour, set_minute, set_weekday, add_count
    input  logic [((23 + YEAR_BITS + ADD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // func
    input  logic                                         s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // cur_day, cur_month, cur_year, cur_hour, cur_minute, cur_weekday
    output logic [((23 + YEAR_BITS + 7) / 8) * 8 - 1:0]  m_tdata,
    // date_rejected, time_rejected, weekday_replaced, add_rejected, year_saturated
    output logic [4:0]                                   m_tuser
);

    localparam int S_BITS = ((23 + YEAR_BITS + ADD_BITS + 7) / 8) * 8;
    localparam int M_BITS = ((23 + YEAR_BITS + 7) / 8) * 8;

    ctl_t  ctl;
    stat_t stat;

    ccam_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    ccam_dp #(
        .YEAR_BITS (YEAR_BITS),
        .ADD_BITS  (ADD_BITS),
        .S_BITS    (S_BITS),
        .M_BITS    (M_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl),
        .stat     (stat)
    );

endmodule
